// File: src/site_pattern_dedup_counter_core_defines.svh
// assertion macros shared by the site pattern dedup counter files
`ifndef SITE_PATTERN_DEDUP_COUNTER_CORE_DEFINES_SVH
`define SITE_PATTERN_DEDUP_COUNTER_CORE_DEFINES_SVH

// clocked assertion, switched off while reset is high
`define SPDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define SPDC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/spdc_pkg.sv
// types, constants and helper functions of the site pattern dedup counter
package spdc_pkg;

  // table and column geometry
  localparam int unsigned MAX_PATTERNS = 256;
  localparam int unsigned MAX_TAXA     = 16;
  localparam int unsigned WEIGHT_BITS  = 20;
  localparam int unsigned NIB_W        = 4;
  localparam int unsigned COL_W        = 64;
  localparam int unsigned TAXA_W       = 5;
  localparam int unsigned IDX_W        = $clog2(MAX_PATTERNS);
  localparam int unsigned CNT_W        = IDX_W + 1;

  // result field widths
  localparam int unsigned OUT_IDX_W = 8;
  localparam int unsigned OUT_WT_W  = 20;

  // control states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } spdc_state_t;

  // nibble mask of the taxa that take part in comparison
  function automatic logic [COL_W-1:0] col_mask(input logic [TAXA_W-1:0] taxa);
    logic [COL_W-1:0] m;
    m = '0;
    for (int t = 0; t < int'(MAX_TAXA); t++) begin
      if (TAXA_W'(t) < taxa) begin
        m[t*NIB_W +: NIB_W] = '1;
      end
    end
    return m;
  endfunction

endpackage

// File: src/spdc_ifs.sv
// valid/ready channel interfaces of the site pattern dedup counter

// column input channel
interface spdc_in_if;
  logic                     valid;
  logic                     ready;
  logic [spdc_pkg::COL_W-1:0] site_column;
  logic                     first_of_partition;

  modport source (output valid, output site_column, output first_of_partition,
                  input ready);
  modport sink (input valid, input site_column, input first_of_partition,
                output ready);
endinterface

// result channel
interface spdc_out_if;
  logic                          valid;
  logic                          ready;
  logic [spdc_pkg::OUT_IDX_W-1:0] pattern_index;
  logic                          is_new;
  logic [spdc_pkg::OUT_WT_W-1:0]  pattern_weight;
  logic                          table_full;

  modport source (output valid, output pattern_index, output is_new,
                  output pattern_weight, output table_full, input ready);
  modport sink (input valid, input pattern_index, input is_new,
                input pattern_weight, input table_full, output ready);
endinterface

// taxa count register write channel
interface spdc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [spdc_pkg::TAXA_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/site_pattern_dedup_counter_core.sv
// Site pattern dedup counter: each column item is matched against the distinct
// patterns of the current partition, which sit in a 256-entry pattern memory and
// a matching weight memory, both with a registered read port. The search walks
// the table one entry per cycle, over the patterns stored in the partition
// when the item arrives; a hit stops the walk early. One item is worked at a
// time; its result waits in a pending result register and the next column is
// taken as soon as the result has been handed over to the output register. No
// clearing pass is needed after reset: only entries below the pattern count are
// ever compared.
`include "site_pattern_dedup_counter_core_defines.svh"

module site_pattern_dedup_counter_core (
  input  logic           clk,
  input  logic           rst,
  spdc_in_if.sink        in_ch,
  spdc_out_if.source     out_ch,
  spdc_cfg_if.sink       cfg
);
  import spdc_pkg::*;

  localparam logic [WEIGHT_BITS-1:0] WT_MAX = '1;
  localparam logic [CNT_W-1:0]       CNT_FULL = CNT_W'(MAX_PATTERNS);

  // memories
  logic [COL_W-1:0]       pat_mem [MAX_PATTERNS];
  logic [WEIGHT_BITS-1:0] wt_mem  [MAX_PATTERNS];

  // control and datapath registers
  spdc_state_t            state, state_next;
  logic [TAXA_W-1:0]      taxa_count;
  logic [CNT_W-1:0]       pattern_count, pattern_count_next;
  logic [CNT_W-1:0]       issue_idx, issue_idx_next;
  logic                   cmp_valid, cmp_valid_next;
  logic [IDX_W-1:0]       cmp_idx, cmp_idx_next;
  logic [COL_W-1:0]       col_q, col_q_next;
  logic [COL_W-1:0]       pat_rd;
  logic [WEIGHT_BITS-1:0] wt_rd;

  // pending result
  logic [IDX_W-1:0]       res_idx, res_idx_next;
  logic                   res_new, res_new_next;
  logic [WEIGHT_BITS-1:0] res_wt, res_wt_next;
  logic                   res_full, res_full_next;

  // output register
  logic                   out_valid, out_valid_next;
  logic [OUT_IDX_W-1:0]   out_idx, out_idx_next;
  logic                   out_new, out_new_next;
  logic [OUT_WT_W-1:0]    out_wt, out_wt_next;
  logic                   out_full, out_full_next;

  // memory ports
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       wr_addr;
  logic                   pat_we, wt_we;
  logic [WEIGHT_BITS-1:0] wt_wdata;

  // compare helpers
  logic [COL_W-1:0]       mask;
  logic                   match;
  logic                   all_issued;
  logic [WEIGHT_BITS-1:0] wt_inc;
  logic                   in_take;
  logic                   out_free;

  assign mask       = col_mask(taxa_count);
  assign match      = cmp_valid && ((pat_rd & mask) == col_q);
  assign all_issued = issue_idx >= pattern_count;
  assign wt_inc     = (wt_rd == WT_MAX) ? wt_rd : wt_rd + 1'b1;
  assign rd_addr    = issue_idx[IDX_W-1:0];

  assign in_ch.ready = (state == ST_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  assign cfg.ready = 1'b1;

  assign out_ch.valid          = out_valid;
  assign out_ch.pattern_index  = out_idx;
  assign out_ch.is_new         = out_new;
  assign out_ch.pattern_weight = out_wt;
  assign out_ch.table_full     = out_full;

  // memory write and read ports
  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[wr_addr] <= col_q;
    end
    if (wt_we) begin
      wt_mem[wr_addr] <= wt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    pat_rd <= pat_mem[rd_addr];
    wt_rd  <= wt_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      taxa_count    <= TAXA_W'(MAX_TAXA);
      pattern_count <= '0;
      cmp_valid     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      pattern_count <= pattern_count_next;
      cmp_valid     <= cmp_valid_next;
      out_valid     <= out_valid_next;
      if (cfg.valid && cfg.ready) begin
        taxa_count <= cfg.data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    issue_idx <= issue_idx_next;
    cmp_idx   <= cmp_idx_next;
    col_q     <= col_q_next;
    res_idx   <= res_idx_next;
    res_new   <= res_new_next;
    res_wt    <= res_wt_next;
    res_full  <= res_full_next;
    out_idx   <= out_idx_next;
    out_new   <= out_new_next;
    out_wt    <= out_wt_next;
    out_full  <= out_full_next;
  end

  // next state, table walk and result handling
  always_comb begin
    state_next         = state;
    pattern_count_next = pattern_count;
    issue_idx_next     = issue_idx;
    cmp_valid_next     = cmp_valid;
    cmp_idx_next       = cmp_idx;
    col_q_next         = col_q;
    res_idx_next       = res_idx;
    res_new_next       = res_new;
    res_wt_next        = res_wt;
    res_full_next      = res_full;
    out_valid_next     = out_valid;
    out_idx_next       = out_idx;
    out_new_next       = out_new;
    out_wt_next        = out_wt;
    out_full_next      = out_full;
    pat_we             = 1'b0;
    wt_we              = 1'b0;
    wr_addr            = cmp_idx;
    wt_wdata           = wt_inc;

    // result taken downstream
    if (out_valid && out_ch.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          col_q_next     = in_ch.site_column & mask;
          issue_idx_next = '0;
          cmp_valid_next = 1'b0;
          if (in_ch.first_of_partition) begin
            pattern_count_next = '0;
          end
          state_next = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (match) begin
          // known column: bump its weight
          wt_we          = 1'b1;
          wr_addr        = cmp_idx;
          wt_wdata       = wt_inc;
          res_idx_next   = cmp_idx;
          res_new_next   = 1'b0;
          res_wt_next    = wt_inc;
          res_full_next  = 1'b0;
          cmp_valid_next = 1'b0;
          state_next     = ST_DONE;
        end else if (all_issued) begin
          // new column: store it or flag a full table
          cmp_valid_next = 1'b0;
          if (pattern_count < CNT_FULL) begin
            pat_we             = 1'b1;
            wt_we              = 1'b1;
            wr_addr            = pattern_count[IDX_W-1:0];
            wt_wdata           = WEIGHT_BITS'(1);
            pattern_count_next = pattern_count + 1'b1;
            res_idx_next       = pattern_count[IDX_W-1:0];
            res_new_next       = 1'b1;
            res_wt_next        = WEIGHT_BITS'(1);
            res_full_next      = 1'b0;
          end else begin
            res_idx_next  = '0;
            res_new_next  = 1'b1;
            res_wt_next   = '0;
            res_full_next = 1'b1;
          end
          state_next = ST_DONE;
        end else begin
          // read the next entry
          cmp_valid_next = 1'b1;
          cmp_idx_next   = issue_idx[IDX_W-1:0];
          issue_idx_next = issue_idx + 1'b1;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_idx_next   = OUT_IDX_W'(res_idx);
          out_new_next   = res_new;
          out_wt_next    = OUT_WT_W'(res_wt);
          out_full_next  = res_full;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // checks on the table walk and the fill count
  `SPDC_ASSERT_ALWAYS(a_count_bound, rst || (pattern_count <= CNT_FULL), "pattern count beyond table size")
  `SPDC_ASSERT(a_issue_bound, (state == ST_SCAN) |-> (issue_idx <= pattern_count), "walk index ran past the count")
  `SPDC_ASSERT(a_cmp_in_table, (state == ST_SCAN && cmp_valid) |-> ({1'b0, cmp_idx} < pattern_count), "compare on an entry outside the table")
  `SPDC_ASSERT(a_store_grows, (pat_we && !in_take) |=> (pattern_count == $past(pattern_count) + 1'b1), "stored pattern did not advance the count")
  `SPDC_ASSERT(a_full_no_store, (state == ST_SCAN && pattern_count == CNT_FULL) |-> !pat_we, "pattern written into a full table")

endmodule
